### rtl/core/scob_pkg.sv
// Package for the span coverage occlusion buffer: command codes, widths and the token type.
package scob_pkg;

    // Default geometry of the coverage line.
    localparam int SCREEN_WIDTH_DEF = 320;
    localparam int WORD_COUNT_DEF   = 10;

    // Bits in one storage word of the coverage line.
    localparam int WORD_BITS = 32;

    // Column index width, wide enough for the largest store of 64 words.
    localparam int COL_W = 11;

    // Command codes carried by the cmd field.
    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // The decoded item as it walks the chain of cells, with its running results.
    typedef struct packed {
        logic             clear;
        logic             span_en;
        logic             mark;
        logic [COL_W-1:0] lo;
        logic [COL_W-1:0] hi;
        logic             vis;
        logic             full;
    } t_token;

endpackage

### rtl/core/scob_in_if.sv
// Interface for the span command channel of the occlusion buffer.
interface scob_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic signed [15:0] left_x;
    logic signed [15:0] right_x;

    modport source (output valid, output cmd, output left_x, output right_x, input ready);
    modport sink   (input valid, input cmd, input left_x, input right_x, output ready);
endinterface

### rtl/core/scob_out_if.sv
// Interface for the result channel of the occlusion buffer.
interface scob_out_if;
    logic valid;
    logic ready;
    logic visible;
    logic line_full;

    modport source (output valid, output visible, output line_full, input ready);
    modport sink   (input valid, input visible, input line_full, output ready);
endinterface

### rtl/core/scob_cell.sv
// One cell of the coverage chain: a 32-column word and the token stage behind it.
module scob_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int ACTIVE_COLS = scob_pkg::SCREEN_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_tok_valid,
    input  scob_pkg::t_token i_tok,
    output logic            o_tok_valid,
    output scob_pkg::t_token o_tok
);

    localparam int BASE = CELL_INDEX * scob_pkg::WORD_BITS;

    logic [scob_pkg::WORD_BITS-1:0] r_word;
    logic [scob_pkg::WORD_BITS-1:0] n_word;
    logic [scob_pkg::WORD_BITS-1:0] w_span_mask;
    logic [scob_pkg::WORD_BITS-1:0] w_active_mask;
    scob_pkg::t_token               r_tok;
    scob_pkg::t_token               n_tok;
    logic                           r_tok_valid;

    // Column k of this word sits at bit 31-k, so column 0 of the line is the MSB of word 0.
    always_comb begin
        logic [scob_pkg::COL_W-1:0] col;
        col = '0;
        for (int k = 0; k < scob_pkg::WORD_BITS; k++) begin
            col = scob_pkg::COL_W'(BASE + k);
            w_span_mask[scob_pkg::WORD_BITS-1-k]   = i_tok.span_en &&
                                                     (col >= i_tok.lo) && (col <= i_tok.hi);
            w_active_mask[scob_pkg::WORD_BITS-1-k] = ((BASE + k) < ACTIVE_COLS);
        end
    end

    always_comb begin
        n_word = r_word;
        if (i_tok.clear) begin
            n_word = '1;
        end else if (i_tok.mark) begin
            n_word = r_word & ~w_span_mask;
        end
        n_tok      = i_tok;
        n_tok.vis  = i_tok.vis | (|(r_word & w_span_mask));
        n_tok.full = i_tok.full & ((n_word & w_active_mask) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '1;
            r_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_tok_valid <= i_tok_valid;
            if (i_tok_valid) begin
                r_word <= n_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

### rtl/core/span_coverage_occlusion_buffer_top.sv
// Top level of the span coverage occlusion buffer: span decode, cell chain and result register.
//
// Usage. Items arrive on i_span (valid/ready): cmd 0 frees every column, cmd 1 tests the
// span left_x..right_x (right exclusive) for any free column, cmd 2 tests it and marks it
// used, cmd 3 does nothing. Each transaction gives exactly one result transaction on
// o_result with visible (some column of the clipped span was free before the item) and
// line_full (no active column is free after the item).
// The item is decoded and clipped into a stage register, then walks the chain of
// WORD_COUNT cells, one cell per cycle while the chain is not stalled, each cell owning
// one 32-column word; after the last cell the result is taken into the output register.
// Items are handled one at a time: a new item is taken only once the earlier token has
// left the last cell of the chain for the output register.
// A new item is taken while an earlier result still waits in the output register.
// Stalls: if the receiver holds ready low, the result stays in the output register;
// a following token parks in the last cell until the register frees up.
// Reset: i_rst_n (synchronous, active low) frees every column and empties the chain
// and the output register.
module span_coverage_occlusion_buffer_top #(
    parameter int SCREEN_WIDTH = scob_pkg::SCREEN_WIDTH_DEF,
    parameter int WORD_COUNT   = scob_pkg::WORD_COUNT_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    scob_in_if.sink    i_span,
    scob_out_if.source o_result
);

    localparam int STORE_COLS  = WORD_COUNT * scob_pkg::WORD_BITS;
    localparam int ACTIVE_COLS = (SCREEN_WIDTH < STORE_COLS) ? SCREEN_WIDTH : STORE_COLS;
    localparam logic signed [16:0] ACTIVE_S = 17'(ACTIVE_COLS);
    localparam logic [scob_pkg::COL_W-1:0] ACTIVE_HI = scob_pkg::COL_W'(ACTIVE_COLS - 1);

    // Token chain: index 0 is the decode stage, index i+1 is the register of cell i.
    logic             w_vld [WORD_COUNT+1];
    scob_pkg::t_token w_tok [WORD_COUNT+1];
    logic [WORD_COUNT:0] w_vld_vec;

    logic             r_busy;
    logic             r_tok0_valid;
    scob_pkg::t_token r_tok0;
    scob_pkg::t_token n_tok0;
    logic             r_out_valid;
    logic             r_visible;
    logic             r_line_full;

    logic w_accept;
    logic w_adv;
    logic w_done;

    logic signed [16:0] w_l;
    logic signed [16:0] w_r;
    logic signed [16:0] w_lo;
    logic signed [16:0] w_hi;

    assign i_span.ready = !r_busy;
    assign w_accept     = i_span.valid && !r_busy;

    // The chain only holds still when a finished token in the last cell cannot move on.
    assign w_done = w_vld[WORD_COUNT] && (!r_out_valid || o_result.ready);
    assign w_adv  = !(w_vld[WORD_COUNT] && r_out_valid && !o_result.ready);

    // Span decode: the exclusive right edge becomes inclusive, the ends are ordered,
    // and the span is clipped to the active part of the line.
    always_comb begin
        w_l  = {i_span.left_x[15], i_span.left_x};
        w_r  = {i_span.right_x[15], i_span.right_x} - 17'sd1;
        w_lo = (w_l > w_r) ? w_r : w_l;
        w_hi = (w_l > w_r) ? w_l : w_r;

        n_tok0         = '0;
        n_tok0.full    = 1'b1;
        n_tok0.lo      = (w_lo < 17'sd0) ? '0 : w_lo[scob_pkg::COL_W-1:0];
        n_tok0.hi      = (w_hi > ACTIVE_S - 17'sd1) ? ACTIVE_HI
                                                      : w_hi[scob_pkg::COL_W-1:0];
        unique case (scob_pkg::t_cmd'(i_span.cmd))
            scob_pkg::CMD_RESET: begin
                n_tok0.clear = 1'b1;
            end
            scob_pkg::CMD_TEST, scob_pkg::CMD_MARK: begin
                n_tok0.mark    = (scob_pkg::t_cmd'(i_span.cmd) == scob_pkg::CMD_MARK);
                // An empty span or one wholly off the line leaves everything untouched.
                n_tok0.span_en = (i_span.left_x != i_span.right_x) &&
                                 (w_lo < ACTIVE_S) && (w_hi >= 17'sd0);
                n_tok0.mark    = n_tok0.mark && n_tok0.span_en;
            end
            scob_pkg::CMD_NOP: begin
                n_tok0.clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_tok0_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_accept) begin
                r_tok0_valid <= 1'b1;
            end else if (w_adv) begin
                r_tok0_valid <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tok0 <= n_tok0;
        end
        if (w_done) begin
            r_visible   <= w_tok[WORD_COUNT].vis;
            r_line_full <= w_tok[WORD_COUNT].full;
        end
    end

    assign w_vld[0] = r_tok0_valid;
    assign w_tok[0] = r_tok0;

    for (genvar g = 0; g < WORD_COUNT; g++) begin : g_cell
        scob_cell #(
            .CELL_INDEX  (g),
            .ACTIVE_COLS (ACTIVE_COLS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (w_adv),
            .i_tok_valid (w_vld[g]),
            .i_tok       (w_tok[g]),
            .o_tok_valid (w_vld[g+1]),
            .o_tok       (w_tok[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i <= WORD_COUNT; i++) begin
            w_vld_vec[i] = w_vld[i];
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.visible   = r_visible;
    assign o_result.line_full = r_line_full;

`ifndef SYNTHESIS
    // Only one item is ever in flight along the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld_vec))
        else $error("more than one token in the cell chain");

    // The busy flag tracks exactly whether a token is somewhere in the chain.
    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (|w_vld_vec))
        else $error("busy flag disagrees with the chain contents");

    // A reset command always finishes as not visible and not full.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[WORD_COUNT] && w_tok[WORD_COUNT].clear) |->
            (!w_tok[WORD_COUNT].vis && !w_tok[WORD_COUNT].full))
        else $error("reset command produced a visible or full result");

    // A token leaving the chain lands in the output register on the next edge.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_out_valid)
        else $error("finished token did not reach the output register");
`endif

endmodule
